### rtl/core/fp32_matrix_multiply_assert.svh
// Assertion macros for the fp32 matrix multiply block.
// Used by fp32_matrix_multiply.sv; needs nothing else.
`ifndef FP32_MATRIX_MULTIPLY_ASSERT_SVH
`define FP32_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FMM_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FMM_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/fmm_pkg.sv
// Shared types and constants of the fp32 matrix multiply block.
// No dependencies.
`default_nettype none

package fmm_pkg;

	localparam int DIM_DEF   = 32;
	localparam int LANES_DEF = 8;

	// register stages in the fused multiply-add unit
	localparam int FMA_LAT = 5;

	localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

	// item opcodes
	localparam logic [1:0] OP_WR_A  = 2'd0;
	localparam logic [1:0] OP_WR_B  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  row;
		logic [4:0]  col;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] product_value;
		logic [4:0]  out_row;
		logic [4:0]  out_col;
	} out_item_t;

	// tag that rides along with an operation through the FMA unit
	typedef struct packed {
		logic       red;
		logic [3:0] lane;
	} fma_tag_t;

endpackage

`default_nettype wire

### rtl/core/fmm_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface fmm_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/fmm_fma.sv
// Pipelined fp32 fused multiply-add, x*y + z, round to nearest even, subnormals kept.
// Five register stages; depends on fmm_pkg.
`default_nettype none

module fmm_fma (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire fmm_pkg::fma_tag_t in_tag,
	input  wire logic [31:0]      x,
	input  wire logic [31:0]      y,
	input  wire logic [31:0]      z,
	output logic                  out_valid,
	output fmm_pkg::fma_tag_t     out_tag,
	output logic [31:0]           res
);
	import fmm_pkg::*;

	// alignment window: product at [50:3], addend at most at [76:53]
	localparam int WIN   = 78;
	localparam int GUARD = 3;
	localparam int ZMAX  = 53;

	// ---------------- stage 1: unpack, specials, multiply ----------------
	logic        sx, sy, sz, sp;
	logic [7:0]  ex, ey, ez, exa, eya, eza;
	logic [22:0] fx, fy, fz;
	logic        x_nan, y_nan, z_nan, x_inf, y_inf, z_inf, x_zero, y_zero, z_zero;
	logic        p_nan, p_inf;
	logic        spec_c;
	logic [31:0] sres_c;

	assign {sx, ex, fx} = x;
	assign {sy, ey, fy} = y;
	assign {sz, ez, fz} = z;
	assign sp = sx ^ sy;
	assign exa = (ex == 8'd0) ? 8'd1 : ex;
	assign eya = (ey == 8'd0) ? 8'd1 : ey;
	assign eza = (ez == 8'd0) ? 8'd1 : ez;
	assign x_nan  = (ex == 8'hFF) && (fx != '0);
	assign y_nan  = (ey == 8'hFF) && (fy != '0);
	assign z_nan  = (ez == 8'hFF) && (fz != '0);
	assign x_inf  = (ex == 8'hFF) && (fx == '0);
	assign y_inf  = (ey == 8'hFF) && (fy == '0);
	assign z_inf  = (ez == 8'hFF) && (fz == '0);
	assign x_zero = (ex == 8'd0) && (fx == '0);
	assign y_zero = (ey == 8'd0) && (fy == '0);
	assign z_zero = (ez == 8'd0) && (fz == '0);
	assign p_nan  = x_nan | y_nan | (x_inf & y_zero) | (x_zero & y_inf);
	assign p_inf  = (x_inf | y_inf) & ~p_nan;

	// results that bypass the datapath
	always_comb begin
		spec_c = 1'b1;
		sres_c = z;
		priority if (p_nan || z_nan || (p_inf && z_inf && (sp != sz))) begin
			sres_c = QNAN_BITS;
		end else if (p_inf) begin
			sres_c = {sp, 8'hFF, 23'd0};
		end else if (z_inf) begin
			sres_c = z;
		end else if (x_zero || y_zero) begin
			sres_c = z_zero ? {sp & sz, 31'd0} : z;
		end else begin
			spec_c = 1'b0;
		end
	end

	logic               v_s1, spec_s1, sp_s1, sz_s1;
	fma_tag_t           tag_s1;
	logic [31:0]        sres_s1;
	logic [47:0]        mp_s1;
	logic [23:0]        mz_s1;
	logic signed [10:0] p_s1;
	logic signed [11:0] lwp_s1, lwz_s1;

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		spec_s1 <= spec_c;
		sres_s1 <= sres_c;
		sp_s1   <= sp;
		sz_s1   <= sz;
		mp_s1   <= {ex != 8'd0, fx} * {ey != 8'd0, fy};
		mz_s1   <= {ez != 8'd0, fz};
		p_s1    <= $signed({3'b0, eza}) - $signed({3'b0, exa}) - $signed({3'b0, eya})
			+ 11'(150 + GUARD);
		lwp_s1  <= $signed({4'b0, exa}) + $signed({4'b0, eya}) - 12'(300 + GUARD);
		lwz_s1  <= $signed({4'b0, eza}) - 12'(150 + ZMAX);
	end

	// ---------------- stage 2: align and add ----------------
	logic [WIN-1:0]     a_c, b_c, mag_c;
	logic [WIN:0]       sum_c, dif_c;
	logic signed [11:0] lw_c;
	logic [4:0]         rsh;
	logic               sgn_c;

	always_comb begin
		a_c  = '0;
		b_c  = '0;
		lw_c = lwp_s1;
		rsh  = 5'(-p_s1);
		if (p_s1 >= 11'(ZMAX)) begin
			// addend far above: product collapses to a sticky bit
			b_c  = WIN'(mz_s1) << ZMAX;
			a_c  = {{(WIN-1){1'b0}}, |mp_s1};
			lw_c = lwz_s1;
		end else begin
			a_c = WIN'(mp_s1) << GUARD;
			if (p_s1 >= 11'sd0) begin
				b_c = WIN'(mz_s1) << p_s1[5:0];
			end else if (p_s1 <= -11'sd24) begin
				b_c = {{(WIN-1){1'b0}}, |mz_s1};
			end else begin
				b_c    = WIN'(mz_s1 >> rsh);
				b_c[0] = b_c[0] | (|(mz_s1 & ~(24'hFF_FFFF << rsh)));
			end
		end
	end

	assign sum_c = {1'b0, a_c} + {1'b0, b_c};
	assign dif_c = {1'b0, a_c} - {1'b0, b_c};

	always_comb begin
		if (sp_s1 == sz_s1) begin
			mag_c = sum_c[WIN-1:0];
			sgn_c = sp_s1;
		end else if (!dif_c[WIN]) begin
			mag_c = dif_c[WIN-1:0];
			sgn_c = sp_s1;
		end else begin
			mag_c = b_c - a_c;
			sgn_c = sz_s1;
		end
	end

	logic               v_s2, spec_s2, sgn_s2;
	fma_tag_t           tag_s2;
	logic [31:0]        sres_s2;
	logic [WIN-1:0]     mag_s2;
	logic signed [11:0] lw_s2;

	always_ff @(posedge clk) begin
		tag_s2  <= tag_s1;
		spec_s2 <= spec_s1;
		sres_s2 <= sres_s1;
		mag_s2  <= mag_c;
		sgn_s2  <= sgn_c;
		lw_s2   <= lw_c;
	end

	// ---------------- stage 3: leading zero count ----------------
	logic [6:0] lz_c;

	always_comb begin
		lz_c = 7'd0;
		for (int i = 0; i < WIN; i++) begin
			if (mag_s2[i]) begin
				lz_c = 7'(WIN - 1 - i);
			end
		end
	end

	logic               v_s3, spec_s3, sgn_s3, zero_s3;
	fma_tag_t           tag_s3;
	logic [31:0]        sres_s3;
	logic [WIN-1:0]     mag_s3;
	logic signed [11:0] lw_s3;
	logic [6:0]         lz_s3;

	always_ff @(posedge clk) begin
		tag_s3  <= tag_s2;
		spec_s3 <= spec_s2;
		sres_s3 <= sres_s2;
		mag_s3  <= mag_s2;
		sgn_s3  <= sgn_s2;
		lw_s3   <= lw_s2;
		lz_s3   <= lz_c;
		zero_s3 <= (mag_s2 == '0);
	end

	// ---------------- stage 4: normalize or denormalize ----------------
	logic signed [12:0] lzs, lim_c, sl_c, expf_c;
	logic               normal_c, lost_c;
	logic [6:0]         rs_c;
	logic [WIN-1:0]     shv_c;

	assign lzs      = $signed({6'b0, lz_s3});
	// shift limit that puts the smallest subnormal weight at the rounding place
	assign lim_c    = 13'(lw_s3) + 13'(WIN - 24 + 149);
	assign normal_c = (lzs <= lim_c);
	assign sl_c     = normal_c ? lzs : lim_c;
	assign expf_c   = 13'(lw_s3) + 13'(WIN - 1 + 127) - lzs;
	assign rs_c     = 7'(-sl_c);

	always_comb begin
		shv_c  = '0;
		lost_c = 1'b0;
		if (sl_c >= 13'sd0) begin
			shv_c = mag_s3 << sl_c[6:0];
		end else if (sl_c <= -13'(WIN)) begin
			lost_c = |mag_s3;
		end else begin
			shv_c  = mag_s3 >> rs_c;
			lost_c = |(mag_s3 & ~({WIN{1'b1}} << rs_c));
		end
	end

	logic        v_s4, spec_s4, sgn_s4, zero_s4, ovf_s4, rnd_s4, stk_s4;
	fma_tag_t    tag_s4;
	logic [31:0] sres_s4;
	logic [23:0] m_s4;
	logic [7:0]  e_s4;

	always_ff @(posedge clk) begin
		tag_s4  <= tag_s3;
		spec_s4 <= spec_s3;
		sres_s4 <= sres_s3;
		sgn_s4  <= sgn_s3;
		zero_s4 <= zero_s3;
		ovf_s4  <= normal_c && (expf_c >= 13'sd255);
		e_s4    <= normal_c ? expf_c[7:0] : 8'd0;
		m_s4    <= shv_c[WIN-1:WIN-24];
		rnd_s4  <= shv_c[WIN-25];
		stk_s4  <= (|shv_c[WIN-26:0]) | lost_c;
	end

	// ---------------- stage 5: round and pack ----------------
	logic        inc_c;
	logic [30:0] body_c;
	logic [31:0] res_c;

	assign inc_c  = rnd_s4 & (stk_s4 | m_s4[0]);
	assign body_c = {e_s4, m_s4[22:0]} + 31'(inc_c);

	always_comb begin
		priority if (spec_s4) begin
			res_c = sres_s4;
		end else if (zero_s4) begin
			res_c = 32'd0;
		end else if (ovf_s4) begin
			res_c = {sgn_s4, 8'hFF, 23'd0};
		end else begin
			res_c = {sgn_s4, body_c};
		end
	end

	always_ff @(posedge clk) begin
		out_tag <= tag_s4;
		res     <= res_c;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

endmodule

`default_nettype wire

### rtl/core/fp32_matrix_multiply.sv
// Top level of the fp32 matrix multiply block: A and B stores, query sequencer.
// Depends on fmm_pkg, fmm_stream_if, fmm_fma and fp32_matrix_multiply_assert.svh.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | op, row, col, value
//   rsp     | out | valid/ready  | product_value, out_row, out_col
//
// A query streams DIM pairs from the two stores into the FMA unit, spaced out by the GAP
// counter, drains, then folds the LANES partial sums one at a time.
// GAP = ceil((FMA_LAT+1)/LANES) keeps a lane off the FMA until its previous sum is back.
// req.ready is high only while idle; a finished result waits in the output register.
// Reset clears control only; store entries hold nothing defined until written.
`default_nettype none
`include "fp32_matrix_multiply_assert.svh"

module fp32_matrix_multiply #(
	parameter int DIM   = fmm_pkg::DIM_DEF,
	parameter int LANES = fmm_pkg::LANES_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fmm_stream_if.sink   req,
	fmm_stream_if.source rsp
);
	import fmm_pkg::*;

	localparam int AW  = $clog2(DIM * DIM);
	localparam int KW  = $clog2(DIM);
	localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int GAP = (FMA_LAT + LANES) / LANES;
	localparam int GW  = $clog2(GAP + 1);
	localparam int IFW = $clog2(FMA_LAT + 3);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DOT   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_RED   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]     state_q;
	logic [KW-1:0]  k_q;
	logic [LW-1:0]  lane_q, red_idx_q, acc_idx;
	logic [GW-1:0]  gap_q;
	logic [IFW-1:0] inflight_q;
	logic           red_busy_q, out_valid_q;
	logic [4:0]     row_q, col_q;
	logic [AW-1:0]  a_addr_q, b_addr_q, wr_addr;
	logic [31:0]    sum_q;
	logic [31:0]    acc_q [LANES];
	out_item_t      out_q;

	logic           accept, in_range, wr_a, wr_b, query_go;
	logic           issue_dot, issue_red, dot_ret, red_ret, load_out;
	logic           dot_phase, fold_go;

	// FMA unit hookup
	logic           fma_in_valid, fma_out_valid;
	fma_tag_t       fma_in_tag, fma_out_tag;
	logic [31:0]    fma_x, fma_y, fma_z, fma_res;

	// memory read stage
	logic           rd_valid_s1;
	logic [LW-1:0]  rd_lane_s1;
	logic [31:0]    ra_s1, rb_s1;
	logic [31:0]    mem_a [DIM * DIM];
	logic [31:0]    mem_b [DIM * DIM];

	// item decode
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = (32'(req.data.row) < 32'(DIM)) && (32'(req.data.col) < 32'(DIM));
	assign wr_addr   = AW'(32'(req.data.row) * 32'(DIM) + 32'(req.data.col));
	assign wr_a      = accept && (req.data.op == OP_WR_A) && in_range;
	assign wr_b      = accept && (req.data.op == OP_WR_B) && in_range;
	assign query_go  = accept && (req.data.op == OP_QUERY);

	assign issue_dot = (state_q == ST_DOT) && (gap_q == '0);
	assign issue_red = (state_q == ST_RED) && !red_busy_q;
	assign dot_ret   = fma_out_valid && !fma_out_tag.red;
	assign red_ret   = fma_out_valid && fma_out_tag.red;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign dot_phase = (state_q == ST_DOT) || (state_q == ST_DRAIN);
	assign fold_go   = (state_q == ST_DRAIN) && (inflight_q == '0);

	// element stores
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= req.data.value;
		end
		if (issue_dot) begin
			ra_s1 <= mem_a[a_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr] <= req.data.value;
		end
		if (issue_dot) begin
			rb_s1 <= mem_b[b_addr_q];
		end
	end

	// operand select for the FMA: dot product step or lane fold
	assign acc_idx      = (state_q == ST_RED) ? red_idx_q : rd_lane_s1;
	assign fma_in_valid = rd_valid_s1 || issue_red;
	assign fma_x        = (state_q == ST_RED) ? ONE_BITS : ra_s1;
	assign fma_y        = (state_q == ST_RED) ? sum_q : rb_s1;
	assign fma_z        = acc_q[acc_idx];
	assign fma_in_tag   = '{red: (state_q == ST_RED), lane: 4'(acc_idx)};

	fmm_fma u_fma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fma_in_valid),
		.in_tag    (fma_in_tag),
		.x         (fma_x),
		.y         (fma_y),
		.z         (fma_z),
		.out_valid (fma_out_valid),
		.out_tag   (fma_out_tag),
		.res       (fma_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			lane_q      <= '0;
			gap_q       <= '0;
			red_idx_q   <= '0;
			red_busy_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue_dot;
			unique case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						state_q <= in_range ? ST_DOT : ST_DONE;
						k_q     <= '0;
						lane_q  <= '0;
						gap_q   <= '0;
					end
				end
				ST_DOT: begin
					if (gap_q != '0) begin
						gap_q <= gap_q - GW'(1);
					end else begin
						gap_q  <= GW'(GAP - 1);
						k_q    <= k_q + KW'(1);
						lane_q <= (lane_q == LW'(LANES - 1)) ? '0 : lane_q + LW'(1);
						if (k_q == KW'(DIM - 1)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (inflight_q == '0) begin
						state_q    <= ST_RED;
						red_idx_q  <= '0;
						red_busy_q <= 1'b0;
					end
				end
				ST_RED: begin
					if (issue_red) begin
						red_busy_q <= 1'b1;
					end
					if (red_ret) begin
						red_busy_q <= 1'b0;
						if (red_idx_q == LW'(LANES - 1)) begin
							state_q <= ST_DONE;
						end else begin
							red_idx_q <= red_idx_q + LW'(1);
						end
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// dot products in flight between memory read and FMA result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({issue_dot, dot_ret})
				2'b10:   inflight_q <= inflight_q + IFW'(1);
				2'b01:   inflight_q <= inflight_q - IFW'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// addresses, partial sums and result payload
	always_ff @(posedge clk) begin
		if (query_go) begin
			row_q    <= req.data.row;
			col_q    <= req.data.col;
			a_addr_q <= AW'(32'(req.data.row) * 32'(DIM));
			b_addr_q <= AW'(req.data.col);
			sum_q    <= '0;
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= '0;
			end
		end
		if (issue_dot) begin
			a_addr_q   <= a_addr_q + AW'(1);
			b_addr_q   <= AW'(32'(b_addr_q) + 32'(DIM));
			rd_lane_s1 <= lane_q;
		end
		if (dot_ret) begin
			acc_q[fma_out_tag.lane[LW-1:0]] <= fma_res;
		end
		if (red_ret) begin
			sum_q <= fma_res;
		end
		if (load_out) begin
			out_q <= '{product_value: sum_q, out_row: row_q, out_col: col_q};
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// checks
	`FMM_ASSERT_IMP(a_idle_quiet, clk, arst_n, state_q == ST_IDLE, !fma_out_valid, "FMA busy idle")
	`FMM_ASSERT_IMP(a_dot_phase, clk, arst_n, dot_ret, dot_phase, "stray dot result")
	`FMM_ASSERT_NXT(a_drain_red, clk, arst_n, fold_go, issue_red, "no lane fold after drain")

endmodule

`default_nettype wire
